FILE: hw/rtl/fia_pkg.sv
// Shared types, constants and helper functions of the frame ID allocator.
`default_nettype none

package fia_pkg;

    // Fixed widths of the request and result fields.
    localparam int unsigned ID_W           = 8;
    localparam int unsigned REQ_W          = 3;

    // The used map is kept as rows of ROW_W marks, one memory word per row.
    localparam int unsigned ROW_BITS       = 4;
    localparam int unsigned ROW_W          = 1 << ROW_BITS;

    // Defaults of the top-level parameters.
    localparam int unsigned ID_COUNT_DEF     = 256;
    localparam int unsigned STATUS_WIDTH_DEF = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_RESERVE = 3'd0,
        REQ_FREE    = 3'd1,
        REQ_CHECK   = 3'd2,
        REQ_SET     = 3'd3,
        REQ_INSERT  = 3'd4,
        REQ_READ    = 3'd5
    } req_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_COMMIT = 1'b1
    } state_t;

    // Marks the IDs of one row that reserve may hand out (1 to id_count-2).
    function automatic logic [ROW_W-1:0] cand_mask(input int unsigned row,
                                                   input int unsigned id_count);
        logic [ROW_W-1:0] m;
        int unsigned      id;
        m = '0;
        for (int unsigned b = 0; b < ROW_W; b++) begin
            id   = (row << ROW_BITS) + b;
            m[b] = (id >= 1) && (id + 2 <= id_count);
        end
        return m;
    endfunction

    // One bit per row: set where the row holds at least one reservable ID.
    function automatic logic [ROW_W-1:0] avail_init(input int unsigned rows,
                                                    input int unsigned id_count);
        logic [ROW_W-1:0] a;
        a = '0;
        for (int unsigned r = 0; r < ROW_W; r++) begin
            a[r] = (r < rows) && (|cand_mask(r, id_count));
        end
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/frame_id_allocator.sv
// Top level of the frame ID allocator: control, used-map and status memories.
//
//  Channel | Direction | Ports                                        | Handshake
//  --------+-----------+----------------------------------------------+------------------
//  request | in        | s_req_type, s_frame_id, s_status_in          | s_valid / s_ready
//  result  | out       | m_granted_id, m_found, m_status_out          | m_valid / m_ready
//
// For each request, in the accepting cycle both memories are read,
// and in the next cycle the row is modified, written back and the result item
// is loaded into the output register. Due to the read-modify-write of the memories,
// a new item is accepted no earlier than the cycle after the result is loaded,
// so the block does not take a new item before it is through with the last.
// Reset (aresetn low, synchronous) clears the row valid bits and the use count and
// loads the free-row summary at once, so there is no clearing pass.
// While a result waits on m_ready the next item is still accepted, provided the
// waiting item is taken in the same cycle; otherwise s_ready stays low.
`default_nettype none

module frame_id_allocator #(
    parameter int unsigned ID_COUNT     = fia_pkg::ID_COUNT_DEF,
    parameter int unsigned STATUS_WIDTH = fia_pkg::STATUS_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [fia_pkg::REQ_W-1:0]    s_req_type,
    input  wire logic [fia_pkg::ID_W-1:0]     s_frame_id,
    input  wire logic [STATUS_WIDTH-1:0]      s_status_in,

    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [fia_pkg::ID_W-1:0]     m_granted_id,
    output logic                              m_found,
    output logic      [STATUS_WIDTH-1:0]      m_status_out
);

    localparam int unsigned ROW_BITS = fia_pkg::ROW_BITS;
    localparam int unsigned ROW_W    = fia_pkg::ROW_W;
    localparam int unsigned ID_W     = fia_pkg::ID_W;
    localparam int unsigned ROWS     = (ID_COUNT + ROW_W - 1) / ROW_W;
    localparam int unsigned ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned ID_AW    = $clog2(ID_COUNT);
    localparam int unsigned CNT_W    = $clog2(ID_COUNT + 1);

    localparam logic [ROW_W-1:0] AVAIL_ALL  = fia_pkg::avail_init(ROWS, ID_COUNT);
    localparam logic [ROWS-1:0]  AVAIL_INIT = AVAIL_ALL[ROWS-1:0];
    localparam logic [CNT_W-1:0] LIMIT      = CNT_W'(ID_COUNT - 1);

    // Control state.
    fia_pkg::state_t state_reg, state_next;
    logic [ROWS-1:0]  avail_reg, avail_next;       // row holds a reservable free ID
    logic [ROWS-1:0]  row_valid_reg, row_valid_next; // row has been written since reset
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    // Request held for the commit cycle.
    logic [fia_pkg::REQ_W-1:0] req_reg;
    logic [ID_W-1:0]           id_reg;
    logic [STATUS_WIDTH-1:0]   st_reg;
    logic                      id_ok_reg;
    logic [ROW_AW-1:0]         row_sel_reg;
    logic                      avail_any_reg;

    // Output register payload.
    logic [ID_W-1:0]         m_granted_id_reg, m_granted_id_next;
    logic                    m_found_reg, m_found_next;
    logic [STATUS_WIDTH-1:0] m_status_out_reg, m_status_out_next;

    // Handshake and memory control.
    logic s_accept;
    logic rd_en;
    logic commit;

    // Read side: the row is the lowest row with a free candidate for reserve,
    // and the row of the named ID for every other request.
    logic              row_any;
    logic [ROW_AW-1:0] row_pick;
    logic [ID_W-1:0]   s_row_full;
    logic [ROW_AW-1:0] rd_row;
    logic              s_id_ok;

    logic [ROW_W-1:0]        used_rdata;
    logic [STATUS_WIDTH-1:0] status_rdata;

    // Commit-cycle datapath.
    logic [ROW_W-1:0]        word;
    logic [ROW_BITS-1:0]     bit_sel;
    logic                    present;
    logic [ROW_W-1:0]        cand;
    logic [ROW_W-1:0]        free_vec;
    logic                    free_any;
    logic [ROW_BITS-1:0]     free_bit;
    logic                    grant;
    logic [ID_W-1:0]         grant_id;
    logic [ROW_W-1:0]        new_word;
    logic                    used_we;
    logic                    st_we;
    logic [ID_AW-1:0]        st_waddr;
    logic [STATUS_WIDTH-1:0] st_wdata;
    logic                    cnt_inc;
    logic                    cnt_dec;
    logic                    found_v;
    logic [STATUS_WIDTH-1:0] stat_v;

    // ------------------------------------------------------------------
    // Read address selection
    // ------------------------------------------------------------------
    fia_lowest #(
        .WIDTH (ROWS),
        .IDX_W (ROW_AW)
    ) u_row_pick (
        .vec (avail_reg),
        .any (row_any),
        .idx (row_pick)
    );

    assign s_row_full = s_frame_id >> ROW_BITS;
    assign s_id_ok    = (32'(s_frame_id) < ID_COUNT);
    assign rd_row     = (s_req_type == fia_pkg::REQ_RESERVE) ? row_pick
                                                             : s_row_full[ROW_AW-1:0];

    // ------------------------------------------------------------------
    // Memories: used map as rows of marks, and the per-ID status codes
    // ------------------------------------------------------------------
    fia_ram #(
        .WIDTH  (ROW_W),
        .DEPTH  (ROWS),
        .ADDR_W (ROW_AW)
    ) u_used_ram (
        .aclk  (aclk),
        .we    (used_we),
        .waddr (row_sel_reg),
        .wdata (new_word),
        .re    (rd_en),
        .raddr (rd_row),
        .rdata (used_rdata)
    );

    fia_ram #(
        .WIDTH  (STATUS_WIDTH),
        .DEPTH  (ID_COUNT),
        .ADDR_W (ID_AW)
    ) u_status_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (rd_en),
        .raddr (s_frame_id[ID_AW-1:0]),
        .rdata (status_rdata)
    );

    // ------------------------------------------------------------------
    // Commit-cycle datapath
    // ------------------------------------------------------------------
    // A row never written since reset reads as all free, whatever the RAM holds.
    assign word     = row_valid_reg[row_sel_reg] ? used_rdata : '0;
    assign bit_sel  = id_reg[ROW_BITS-1:0];
    assign present  = id_ok_reg && word[bit_sel];
    assign cand     = fia_pkg::cand_mask(32'(row_sel_reg), ID_COUNT);
    assign free_vec = ~word & cand;

    fia_lowest #(
        .WIDTH (ROW_W),
        .IDX_W (ROW_BITS)
    ) u_bit_pick (
        .vec (free_vec),
        .any (free_any),
        .idx (free_bit)
    );

    assign grant_id = ID_W'((32'(row_sel_reg) << ROW_BITS) | 32'(free_bit));

    always_comb begin
        grant    = 1'b0;
        new_word = word;
        used_we  = 1'b0;
        st_we    = 1'b0;
        st_waddr = id_reg[ID_AW-1:0];
        st_wdata = st_reg;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        found_v  = 1'b0;
        stat_v   = '0;
        unique case (req_reg)
            fia_pkg::REQ_RESERVE: begin
                // Reserve is refused once the count reaches the limit.
                grant = (count_reg < LIMIT) && avail_any_reg && free_any;
                if (grant) begin
                    new_word[free_bit] = 1'b1;
                    used_we            = 1'b1;
                    st_we              = 1'b1;
                    st_waddr           = grant_id[ID_AW-1:0];
                    st_wdata           = '0;
                    cnt_inc            = 1'b1;
                end
            end
            fia_pkg::REQ_FREE: begin
                found_v = present;
                if (present) begin
                    new_word[bit_sel] = 1'b0;
                    used_we           = 1'b1;
                    cnt_dec           = 1'b1;
                end
            end
            fia_pkg::REQ_CHECK: begin
                found_v = present;
            end
            fia_pkg::REQ_SET: begin
                found_v = present;
                st_we   = present;
            end
            fia_pkg::REQ_INSERT: begin
                // An insert of an in-range ID writes the status, and marks the ID used
                // only when it was free.
                found_v = present;
                if (id_ok_reg) begin
                    st_we = 1'b1;
                    if (!present) begin
                        new_word[bit_sel] = 1'b1;
                        used_we           = 1'b1;
                        cnt_inc           = 1'b1;
                    end
                end
            end
            fia_pkg::REQ_READ: begin
                found_v = present;
                stat_v  = present ? status_rdata : '0;
            end
            default: begin
                // Unknown request codes leave the state alone.
            end
        endcase
        used_we = used_we && commit;
        st_we   = st_we && commit;
    end

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fia_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = fia_pkg::ST_COMMIT;
                end
            end
            fia_pkg::ST_COMMIT: begin
                state_next = fia_pkg::ST_IDLE;
            end
            default: begin
                state_next = fia_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        commit  = 1'b0;
        unique case (state_reg)
            fia_pkg::ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
            end
            fia_pkg::ST_COMMIT: begin
                commit = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign s_accept = s_valid && s_ready;
    assign rd_en    = s_accept;

    // ------------------------------------------------------------------
    // Next values of the control state and the output register
    // ------------------------------------------------------------------
    always_comb begin
        avail_next     = avail_reg;
        row_valid_next = row_valid_reg;
        count_next     = count_reg;
        if (used_we) begin
            avail_next[row_sel_reg]     = |(~new_word & cand);
            row_valid_next[row_sel_reg] = 1'b1;
        end
        if (commit && cnt_inc) begin
            count_next = count_reg + CNT_W'(1);
        end else if (commit && cnt_dec) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next      = m_valid_reg;
        m_granted_id_next = m_granted_id_reg;
        m_found_next      = m_found_reg;
        m_status_out_next = m_status_out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (commit) begin
            m_valid_next      = 1'b1;
            m_granted_id_next = grant ? grant_id : '0;
            m_found_next      = found_v;
            m_status_out_next = stat_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fia_pkg::ST_IDLE;
            avail_reg     <= AVAIL_INIT;
            row_valid_reg <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            avail_reg     <= avail_next;
            row_valid_reg <= row_valid_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Request capture and result payload need no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg       <= s_req_type;
            id_reg        <= s_frame_id;
            st_reg        <= s_status_in;
            id_ok_reg     <= s_id_ok;
            row_sel_reg   <= rd_row;
            avail_any_reg <= row_any;
        end
        m_granted_id_reg <= m_granted_id_next;
        m_found_reg      <= m_found_next;
        m_status_out_reg <= m_status_out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_granted_id = m_granted_id_reg;
    assign m_found      = m_found_reg;
    assign m_status_out = m_status_out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fia_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module fia_ram #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fia_lowest.sv
// Lowest-set-bit encoder used to pick a row and a free ID within a row.
`default_nettype none

module fia_lowest #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  wire logic [WIDTH-1:0] vec,
    output logic                  any,
    output logic      [IDX_W-1:0] idx
);

    always_comb begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IDX_W'(i);
            end
        end
        any = |vec;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fia_checker.sv
// Port-level checker for the frame ID allocator and its bind statement.
`default_nettype none

module fia_port_props #(
    parameter int unsigned STATUS_WIDTH = fia_pkg::STATUS_WIDTH_DEF
) (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [fia_pkg::ID_W-1:0]  m_granted_id,
    input wire logic                      m_found,
    input wire logic [STATUS_WIDTH-1:0]   m_status_out
);

    // A stalled result item holds its payload.
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_id)
                                && $stable(m_found) && $stable(m_status_out);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result item changed while stalled");

    // Every accepted item is worked on in the commit state, with s_ready low, then its result appears.
    property p_latency;
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 m_valid;
    endproperty
    a_latency: assert property (p_latency) else $error("result did not follow accepted item");

    // A granted ID comes only from reserve, which reports nothing else.
    property p_grant_clean;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && (m_granted_id != '0) |-> !m_found && (m_status_out == '0);
    endproperty
    a_grant_clean: assert property (p_grant_clean) else $error("grant with found or status");

    // Reserve never hands out the top ID.
    property p_grant_range;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_granted_id != {fia_pkg::ID_W{1'b1}};
    endproperty
    a_grant_range: assert property (p_grant_range) else $error("top ID granted");

endmodule

bind frame_id_allocator fia_port_props #(
    .STATUS_WIDTH (STATUS_WIDTH)
) u_fia_port_props (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_granted_id (m_granted_id),
    .m_found      (m_found),
    .m_status_out (m_status_out)
);

`default_nettype wire
